>>> hw/rtl/pidaw_pkg.sv
// shared types, widths and register codes of the pid controller
package pidaw_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned RawW    = 17;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned DiffW   = 19;
  localparam int unsigned SumW    = 32;
  localparam int unsigned NextW   = 33;
  localparam int unsigned ProdW   = 49;
  localparam int unsigned AccW    = 50;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [DataW-1:0] OutMinRst = -16'sd127;
  localparam logic signed [DataW-1:0] OutMaxRst = 16'sd127;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_INPUT_SPAN = 3'd3,
    REG_OUT_MIN    = 3'd4,
    REG_OUT_MAX    = 3'd5,
    REG_TOLERANCE  = 3'd6,
    REG_RUN_ENABLE = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic        [DataW-1:0] input_span;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
    logic        [DataW-1:0] tolerance;
    logic                    run_enable;
  } cfg_t;

endpackage

>>> hw/rtl/pidaw_if.sv
// handshake channels of the pid controller: samples, results, register writes
interface pidaw_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measurement;
  logic signed [15:0] target;

  modport source (output valid, output measurement, output target, input ready);
  modport sink   (input valid, input measurement, input target, output ready);
endinterface

interface pidaw_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               on_target;

  modport source (output valid, output drive, output on_target, input ready);
  modport sink   (input valid, input drive, input on_target, output ready);
endinterface

interface pidaw_cfg_if;
  logic                        valid;
  logic                        ready;
  pidaw_pkg::cfg_idx_e         index;
  logic [15:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/pid_controller_wrap_antiwindup.sv
// pid controller with error wrapping and integral anti-windup, one shared multiplier
//
//   channel   dir  modport  payload                      handshake
//   sample_i  in   sink     measurement, target          valid/ready
//   result_o  out  source   drive, on_target             valid/ready
//   cfg_i     in   sink     index (3 bit), data (16 bit) valid/ready, always ready
//
// an enabled sample steps through err, intm, intc, dm, im, acc and clp, as the four
// products go one after another through the single 16x33 multiplier; a disabled
// sample goes from err straight to clp. a new sample is taken only in idle, also
// while the last result still waits in the output register; the sequencer holds
// in its final step while that register is full and not taken. reset clears the
// integral, the last error and the output valid, and sets the registers to defaults.
module pid_controller_wrap_antiwindup (
  input  logic         clk_i,
  input  logic         rst_ni,
  pidaw_sample_if.sink sample_i,
  pidaw_result_if.source result_o,
  pidaw_cfg_if.sink    cfg_i
);
  import pidaw_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_ERR  = 8'b0000_0010,
    ST_INTM = 8'b0000_0100,
    ST_INTC = 8'b0000_1000,
    ST_DM   = 8'b0001_0000,
    ST_IM   = 8'b0010_0000,
    ST_ACC  = 8'b0100_0000,
    ST_CLP  = 8'b1000_0000
  } state_e;

  cfg_t cfg;

  pidaw_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  state_e state_q, state_d;

  logic signed [RawW-1:0]  raw_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [ErrW-1:0]  last_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [NextW-1:0] next_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    on_tgt_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] drive_q;
  logic                    out_on_tgt_q;

  logic                    in_beat;
  logic                    out_load;
  logic signed [RawW-1:0]  raw_d;
  logic        [RawW-1:0]  mag;
  logic                    wrap;
  logic signed [ErrW-1:0]  raw_x;
  logic signed [ErrW-1:0]  span_x;
  logic signed [ErrW-1:0]  err_wrap;
  logic signed [NextW-1:0] next_d;
  logic signed [DiffW-1:0] diff;
  logic signed [DataW-1:0] mul_a;
  logic signed [NextW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [ProdW-1:0] lo_p, hi_p;
  logic signed [AccW-1:0]  lo_a, hi_a;
  logic                    in_range;
  logic signed [SumW-1:0]  next_sat;
  logic signed [DataW-1:0] clamp;

  assign in_beat  = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_CLP) && (!out_valid_q || result_o.ready);

  assign result_o.valid     = out_valid_q;
  assign result_o.drive     = drive_q;
  assign result_o.on_target = out_on_tgt_q;

  // error and wrapping
  assign raw_d    = {sample_i.target[DataW-1], sample_i.target}
                  - {sample_i.measurement[DataW-1], sample_i.measurement};
  assign mag      = raw_q[RawW-1] ? RawW'(-raw_q) : RawW'(raw_q);
  assign wrap     = mag > {2'b00, cfg.input_span[DataW-1:1]};
  assign raw_x    = {raw_q[RawW-1], raw_q};
  assign span_x   = {2'b00, cfg.input_span};
  assign err_wrap = !wrap ? raw_x : (raw_q[RawW-1] ? raw_x + span_x : raw_x - span_x);
  assign next_d   = {sum_q[SumW-1], sum_q} + {{(NextW-ErrW){err_wrap[ErrW-1]}}, err_wrap};
  assign diff     = {err_q[ErrW-1], err_q} - {last_q[ErrW-1], last_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = cfg.gain_i;
    mul_b = next_q;
    unique case (state_q)
      ST_INTC: begin
        mul_a = cfg.gain_p;
        mul_b = {{(NextW-ErrW){err_q[ErrW-1]}}, err_q};
      end
      ST_DM: begin
        mul_a = cfg.gain_d;
        mul_b = {{(NextW-DiffW){diff[DiffW-1]}}, diff};
      end
      ST_IM: begin
        mul_a = cfg.gain_i;
        mul_b = {sum_q[SumW-1], sum_q};
      end
      default: begin
        mul_a = cfg.gain_i;
        mul_b = next_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // anti-windup window and saturation
  assign lo_p     = {{(ProdW-DataW){cfg.out_min[DataW-1]}}, cfg.out_min};
  assign hi_p     = {{(ProdW-DataW){cfg.out_max[DataW-1]}}, cfg.out_max};
  assign in_range = (prod_q < hi_p) && (prod_q > lo_p);

  always_comb begin
    next_sat = next_q[SumW-1:0];
    if (!next_q[NextW-1] && next_q[SumW-1]) begin
      next_sat = {1'b0, {(SumW-1){1'b1}}};
    end else if (next_q[NextW-1] && !next_q[SumW-1]) begin
      next_sat = {1'b1, {(SumW-1){1'b0}}};
    end
  end

  // output clamp, upper bound tested first
  assign lo_a = {{(AccW-DataW){cfg.out_min[DataW-1]}}, cfg.out_min};
  assign hi_a = {{(AccW-DataW){cfg.out_max[DataW-1]}}, cfg.out_max};

  always_comb begin
    clamp = acc_q[DataW-1:0];
    if (acc_q > hi_a) begin
      clamp = cfg.out_max;
    end else if (acc_q < lo_a) begin
      clamp = cfg.out_min;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_beat) state_d = ST_ERR;
      ST_ERR:  state_d = cfg.run_enable ? ST_INTM : ST_CLP;
      ST_INTM: state_d = ST_INTC;
      ST_INTC: state_d = ST_DM;
      ST_DM:   state_d = ST_IM;
      ST_IM:   state_d = ST_ACC;
      ST_ACC:  state_d = ST_CLP;
      ST_CLP:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      last_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_INTC && in_range) begin
        sum_q <= next_sat;
      end
      if (state_q == ST_DM) begin
        last_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      raw_q <= raw_d;
    end
    if (state_q == ST_ERR) begin
      err_q    <= err_wrap;
      next_q   <= next_d;
      on_tgt_q <= (mag <= {1'b0, cfg.tolerance});
    end
    prod_q <= mul_p;
    unique case (state_q)
      ST_INTC: acc_q <= '0;
      ST_DM,
      ST_IM,
      ST_ACC:  acc_q <= acc_q + {prod_q[ProdW-1], prod_q};
      default: acc_q <= acc_q;
    endcase
    if (out_load) begin
      drive_q      <= cfg.run_enable ? clamp : '0;
      out_on_tgt_q <= on_tgt_q;
    end
  end

  // a result only ever comes out of the final step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_CLP))
    else $error("result raised outside the final step");

  // disabled samples leave the integral and the last error alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERR && !cfg.run_enable) |=> ($stable(sum_q) && $stable(last_q)))
    else $error("state changed on a disabled sample");

  // a disabled sample yields zero drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !cfg.run_enable) |=> (drive_q == '0))
    else $error("nonzero drive while disabled");

  // an enabled drive lies in the range when the range is ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && cfg.run_enable && (cfg.out_min <= cfg.out_max))
      |=> ((drive_q >= $past(cfg.out_min)) && (drive_q <= $past(cfg.out_max))))
    else $error("drive outside the output range");

endmodule

>>> hw/rtl/pidaw_regs.sv
// configuration register file of the pid controller
module pidaw_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  pidaw_cfg_if.sink       cfg_i,
  output pidaw_pkg::cfg_t cfg_o
);
  import pidaw_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_GAIN_P:     cfg_d.gain_p     = cfg_i.data;
        REG_GAIN_I:     cfg_d.gain_i     = cfg_i.data;
        REG_GAIN_D:     cfg_d.gain_d     = cfg_i.data;
        REG_INPUT_SPAN: cfg_d.input_span = cfg_i.data;
        REG_OUT_MIN:    cfg_d.out_min    = cfg_i.data;
        REG_OUT_MAX:    cfg_d.out_max    = cfg_i.data;
        REG_TOLERANCE:  cfg_d.tolerance  = cfg_i.data;
        REG_RUN_ENABLE: cfg_d.run_enable = cfg_i.data[0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // gains and span zero, default drive range, tolerance zero, disabled
      cfg_q <= {{(4*DataW){1'b0}}, OutMinRst, OutMaxRst, {DataW{1'b0}}, 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> tb/pid_controller_wrap_antiwindup_test.sv
// testbench for the pid controller: directed and random samples checked against a predictor
`timescale 1ns / 1ps

module pid_controller_wrap_antiwindup_test;
  import pidaw_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 10;
  localparam int PhaseItems = 175;
  localparam int ReconfigEvery = 40;
  localparam int ClimbItems = 24;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               on_target;
  } pid_result_t;

  class pid_scoreboard;
    logic signed [15:0] kp, ki, kd, lo_lim, hi_lim;
    logic [15:0]        span, tol;
    logic               run;
    logic signed [31:0] integ;
    logic signed [17:0] prev_err;
    pid_result_t        expected_q[$];
    int                 errors;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      span = '0;
      lo_lim = OutMinRst;
      hi_lim = OutMaxRst;
      tol = '0;
      run = 1'b0;
      integ = '0;
      prev_err = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        REG_GAIN_P:     kp = value;
        REG_GAIN_I:     ki = value;
        REG_GAIN_D:     kd = value;
        REG_INPUT_SPAN: span = value;
        REG_OUT_MIN:    lo_lim = value;
        REG_OUT_MAX:    hi_lim = value;
        REG_TOLERANCE:  tol = value;
        REG_RUN_ENABLE: run = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advances the loop state by one sample and queues the result it must give
    function void note_sample(logic signed [15:0] meas, logic signed [15:0] tgt);
      longint      raw, mag, err, nxt, prod, drv, lo, hi, sp;
      pid_result_t res;
      raw = longint'(tgt) - longint'(meas);
      mag = raw < 0 ? -raw : raw;
      lo = longint'(lo_lim);
      hi = longint'(hi_lim);
      drv = 0;
      if (run) begin
        sp = longint'(span);
        err = raw;
        if (mag > sp / 2) begin
          err = err > 0 ? err - sp : err + sp;
        end
        nxt = longint'(integ) + err;
        prod = nxt * longint'(ki);
        // anti-windup: only take the new sum while ki*sum stays inside the range
        if (prod < hi && prod > lo) begin
          if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
          else if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
          integ = nxt[31:0];
        end
        drv = longint'(kp) * err + longint'(ki) * longint'(integ)
            + longint'(kd) * (err - longint'(prev_err));
        prev_err = err[17:0];
        if (drv > hi) drv = hi;
        else if (drv < lo) drv = lo;
      end
      res.drive = drv[15:0];
      res.on_target = (mag <= longint'(tol));
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [15:0] drive, logic on_target);
      pid_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result drive=%0d on_target=%0b", drive, on_target));
      end else begin
        exp_res = expected_q.pop_front();
        if (drive !== exp_res.drive)
          report($sformatf("drive got %0d want %0d", drive, exp_res.drive));
        if (on_target !== exp_res.on_target)
          report($sformatf("on_target got %0b want %0b", on_target, exp_res.on_target));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  pidaw_sample_if sample_if ();
  pidaw_result_if result_if ();
  pidaw_cfg_if    cfg_if ();

  pid_controller_wrap_antiwindup DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  pid_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int holds_started;
    int hold_left;
    holds_started = 0;
    hold_left = 0;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.drive, result_if.on_target);
      if (hold_left == 0 && holds_started != hold_requests) begin
        holds_started++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [15:0] meas, logic signed [15:0] tgt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.measurement <= meas;
    sample_if.target <= tgt;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    sb.note_sample(meas, tgt);
  endtask

  // wait for every queued result, then give the pipeline time to settle
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                           logic [15:0] sp, logic [15:0] lo, logic [15:0] hi,
                           logic [15:0] tl, logic en);
    drain();
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_INPUT_SPAN, sp);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_TOLERANCE, tl);
    write_reg(REG_RUN_ENABLE, {15'd0, en});
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_word(int spread);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 2 * spread) - spread);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] sp, lo, hi, tl;
    case ($urandom_range(0, 3))
      0: begin
        lo = 16'h8000;
        hi = 16'h7fff;
      end
      1: begin
        lo = pick_word(3000);
        hi = pick_word(3000);
      end
      default: begin
        lo = 16'(-$urandom_range(0, 2000));
        hi = 16'($urandom_range(0, 2000));
      end
    endcase
    case ($urandom_range(0, 3))
      0: sp = 16'h0000;
      1: sp = 16'hffff;
      2: sp = 16'($urandom);
      default: sp = 16'($urandom_range(100, 4000));
    endcase
    case ($urandom_range(0, 3))
      0: tl = 16'h0000;
      1: tl = 16'hffff;
      2: tl = 16'($urandom_range(0, 200));
      default: tl = 16'($urandom);
    endcase
    configure(pick_word(8), pick_word(4), pick_word(8), sp, lo, hi, tl,
              $urandom_range(0, 9) != 0);
  endtask

  task automatic random_sample();
    logic signed [15:0] meas, tgt;
    meas = 16'($urandom);
    case ($urandom_range(0, 4))
      0: tgt = meas + 16'($urandom_range(0, 40)) - 16'd20;
      1: begin
        meas = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        tgt = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      end
      default: tgt = 16'($urandom);
    endcase
    send_sample(meas, tgt);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < PhaseItems; i++) begin
      if (i % ReconfigEvery == 0) random_config();
      if (with_hold && i == 20) hold_requests++;
      // sender waits for the block to run empty mid-phase
      if (i == PhaseItems / 2 + 7) drain();
      random_sample();
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    sample_if.valid = 1'b0;
    sample_if.measurement = '0;
    sample_if.target = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_GAIN_P;
    cfg_if.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: disabled, on_target still reported
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd32767);

    configure(16'd1, 16'd1, 16'd1, 16'd0, 16'h8000, 16'h7fff, 16'hffff, 1'b1);
    send_sample(16'sd0, 16'sd100);
    send_sample(16'sd100, 16'sd0);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd5, 16'sd5);

    // wrapping around a span of 1000
    configure(16'd3, 16'd0, -16'sd2, 16'd1000, -16'sd500, 16'sd500, 16'd10, 1'b1);
    send_sample(16'sd0, 16'sd600);
    send_sample(16'sd0, -16'sd600);
    send_sample(16'sd0, 16'sd500);
    send_sample(16'sd0, 16'sd501);
    send_sample(-16'sd300, 16'sd300);
    send_sample(16'sd0, 16'sd10);
    send_sample(16'sd0, 16'sd11);

    configure(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff, 16'd0, 1'b1);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd0, 16'sd32767);
    send_sample(16'sd0, -16'sd32768);

    // inverted output range
    configure(16'd1, 16'd1, 16'd0, 16'd0, 16'sd100, -16'sd100, 16'd0, 1'b1);
    send_sample(16'sd0, 16'sd50);
    send_sample(16'sd0, -16'sd200);
    send_sample(16'sd0, 16'sd0);

    configure(16'd1, 16'd1, 16'd1, 16'd0, 16'h8000, 16'h7fff, 16'd4, 1'b0);
    send_sample(16'sd1, 16'sd2);
    send_sample(16'sd7, 16'sd3);

    run_phase(0, 0, 1'b1);
    run_phase(60, 0, 1'b0);
    run_phase(0, 60, 1'b0);
    run_phase(30, 30, 1'b1);

    // ki of zero lets the sum climb far past the drive range, then the window holds it
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'd1, 16'd0, 1'b1);
    for (int i = 0; i < ClimbItems; i++) send_sample(-16'sd32768, 16'sd32767);
    configure(16'd0, 16'd1, 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'd0, 1'b1);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd0, -16'sd5);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_if.sv
hw/rtl/pidaw_regs.sv
hw/rtl/pid_controller_wrap_antiwindup.sv
tb/pid_controller_wrap_antiwindup_test.sv
